// File: design/mdfr_pkg.sv
// shared types and constants for the mesh duplicate filter relay
// holds the store entry layout, the result layout, action and kind codes and fsm states
// no dependencies
package mdfr_pkg;

  localparam int unsigned MAC_W     = 48;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned KIND_W    = 8;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned OCC_W     = 5;
  localparam int unsigned ENTRIES_D = 16;

  localparam logic [KIND_W-1:0] KIND_BCAST    = 8'd1;
  localparam logic [KIND_W-1:0] KIND_TARGETED = 8'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_OWN      = 3'd0,
    ACT_DUP      = 3'd1,
    ACT_DELIVER  = 3'd2,
    ACT_BCAST    = 3'd3,
    ACT_TARGETED = 3'd4,
    ACT_PASS     = 3'd5
  } action_t;

  typedef struct packed {
    logic [MAC_W-1:0] origin;
    logic [MAC_W-1:0] sender;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef struct packed {
    action_t          action;
    logic [OCC_W-1:0] occupancy;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DONE
  } state_t;

endpackage

// File: design/mdfr_store.sv
// seen-message store: one write port, one read port with registered read data
// depends on mdfr_pkg for the entry layout
module mdfr_store #(
  parameter int unsigned ENTRIES = mdfr_pkg::ENTRIES_D,
  parameter int unsigned AW      = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  mdfr_pkg::entry_t  wdata,
  input  logic [AW-1:0]     raddr,
  output mdfr_pkg::entry_t  rdata
);
  import mdfr_pkg::*;

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/mdfr_ctrl.sv
// sequencer for the duplicate filter: own check, store search, shift insert, run rescan
// depends on mdfr_pkg; drives the mdfr_store ports
module mdfr_ctrl #(
  parameter int unsigned ENTRIES = mdfr_pkg::ENTRIES_D,
  parameter int unsigned AW      = 4,
  parameter int unsigned CW      = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [mdfr_pkg::MAC_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mdfr_pkg::KIND_W-1:0]  in_kind,
  input  logic [mdfr_pkg::MAC_W-1:0]   in_target,
  input  mdfr_pkg::entry_t             in_entry,
  output logic                         res_valid,
  input  logic                         res_ready,
  output mdfr_pkg::res_t               res,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output mdfr_pkg::entry_t             mem_wdata,
  output logic [AW-1:0]                mem_raddr,
  input  mdfr_pkg::entry_t             mem_rdata
);
  import mdfr_pkg::*;

  localparam logic [CW-1:0] ENT_C  = CW'(ENTRIES);
  localparam logic [CW-1:0] LAST_C = CW'(ENTRIES - 1);
  localparam logic [CW-1:0] ONE_C  = CW'(1);

  state_t             state, state_next;
  logic [CW-1:0]      ptr, ptr_next;
  logic [CW-1:0]      lead, lead_next;
  action_t            act, act_next;
  logic [MAC_W-1:0]   self_mac;
  logic [KIND_W-1:0]  item_kind;
  logic [MAC_W-1:0]   item_target;
  entry_t             item;
  logic [CW-1:0]      shift_top;
  logic               hit;

  assign shift_top = (lead == ENT_C) ? LAST_C : lead;
  assign hit       = (mem_rdata.id == item.id) && (mem_rdata.origin == item.origin);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      ptr      <= '0;
      lead     <= '0;
      act      <= ACT_OWN;
      self_mac <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      lead  <= lead_next;
      act   <= act_next;
      if (cfg_we) begin
        self_mac <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_kind   <= in_kind;
      item_target <= in_target;
      item        <= in_entry;
    end
  end

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    lead_next  = lead;
    act_next   = act;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = ptr[AW-1:0];
    mem_wdata  = mem_rdata;
    mem_raddr  = ptr[AW-1:0];
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (ptr == LAST_C) begin
          ptr_next   = '0;
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr + ONE_C;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (item.origin == self_mac) begin
          act_next   = ACT_OWN;
          state_next = ST_DONE;
        end else if (lead == '0) begin
          ptr_next   = '0;
          state_next = ST_INSERT;
        end else begin
          ptr_next   = '0;
          state_next = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        state_next = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        if (hit) begin
          act_next   = ACT_DUP;
          state_next = ST_DONE;
        end else if (ptr + ONE_C == lead) begin
          ptr_next   = shift_top;
          state_next = (shift_top == '0) ? ST_INSERT : ST_SHIFT_RD;
        end else begin
          ptr_next   = ptr + ONE_C;
          state_next = ST_SRCH_RD;
        end
      end
      ST_SHIFT_RD: begin
        // fetch the entry in front, it moves back into slot ptr
        mem_raddr  = AW'(ptr - ONE_C);
        state_next = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        mem_we = 1'b1;
        if (ptr == ONE_C) begin
          state_next = ST_INSERT;
        end else begin
          state_next = ST_SHIFT_RD;
        end
        ptr_next = ptr - ONE_C;
      end
      ST_INSERT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = item;
        if (item_target == self_mac) begin
          act_next = ACT_DELIVER;
        end else if (item_kind == KIND_BCAST) begin
          act_next = ACT_BCAST;
        end else if (item_kind == KIND_TARGETED) begin
          act_next = ACT_TARGETED;
        end else begin
          act_next = ACT_PASS;
        end
        // new run length: zero id empties it, a filled store is full, else rescan
        if (item.id == '0) begin
          lead_next  = '0;
          state_next = ST_DONE;
        end else if (lead == ENT_C || lead + ONE_C == ENT_C) begin
          lead_next  = ENT_C;
          state_next = ST_DONE;
        end else begin
          ptr_next   = lead + ONE_C;
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        state_next = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (mem_rdata.id == '0) begin
          lead_next  = ptr;
          state_next = ST_DONE;
        end else if (ptr + ONE_C == ENT_C) begin
          lead_next  = ENT_C;
          state_next = ST_DONE;
        end else begin
          ptr_next   = ptr + ONE_C;
          state_next = ST_SCAN_RD;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign res.action    = act;
  assign res.occupancy = OCC_W'(lead);

`ifndef SYNTHESIS
  a_lead_range: assert property (@(posedge clk) disable iff (rst)
    lead <= ENT_C)
    else $error("run length beyond store depth");
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == ST_CHECK)
    else $error("accepted item not checked next");
  a_zero_id_empties: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INSERT && item.id == '0) |=> lead == '0)
    else $error("zero id insert left a nonempty run");
  a_shift_addr: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHIFT_WR |-> (mem_we && mem_waddr != '0))
    else $error("shift write hit the front slot");
  a_drop_keeps_lead: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH_CMP && hit) |=> $stable(lead))
    else $error("duplicate drop changed the run length");
`endif

endmodule

// File: design/mesh_duplicate_filter_relay_unit.sv
// one item at a time: accept, own check, a read and a compare per searched entry, a read
//   and a write per shifted entry, insert, a read and a compare per rescanned entry behind
//   the run, then the result; an own frame ends at the check, a duplicate at its compare
// reset: sync active-high rst clears control and self_mac, then a clearing pass writes
//   empty slots into every store entry while no input transfer is taken
// depends on mdfr_pkg, mdfr_store, mdfr_ctrl
module mesh_duplicate_filter_relay_unit #(
  parameter int unsigned ENTRIES = mdfr_pkg::ENTRIES_D
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mdfr_pkg::MAC_W-1:0]  cfg_wdata,   // self_mac
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [159:0]                s_tdata,     // origin_mac, target_mac, msg_id, sender_mac
  input  logic [7:0]                  s_tuser,     // msg_kind
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,     // occupancy, zero pad
  output logic [2:0]                  m_tuser      // action
);
  import mdfr_pkg::*;

  // address width for the store, count width able to hold ENTRIES itself
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  entry_t          in_entry;
  logic [MAC_W-1:0] in_target;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  entry_t          mem_wdata;
  entry_t          mem_rdata;
  logic            res_valid;
  logic            res_ready;
  res_t            res;

  // unpack the header, first field in the lowest bits
  assign in_entry.origin = s_tdata[47:0];
  assign in_target       = s_tdata[95:48];
  assign in_entry.id     = s_tdata[111:96];
  assign in_entry.sender = s_tdata[159:112];

  mdfr_store #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mdfr_ctrl #(
    .ENTRIES (ENTRIES),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser),
    .in_target (in_target),
    .in_entry  (in_entry),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output register: the result waits here while the sequencer takes the next transfer
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tuser <= res.action;
      m_tdata <= {3'b000, res.occupancy};
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");
  a_action_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= ACT_PASS)
    else $error("action code out of range");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped while output busy");
`endif

endmodule

// File: tb/sv/mesh_duplicate_filter_relay_unit_tb.sv
// self-checking bench for mesh_duplicate_filter_relay_unit: frame headers in, verdicts out
// keeps its own copy of the seen-message store and predicts the action and occupancy
// depends on mdfr_pkg and mesh_duplicate_filter_relay_unit
module mesh_duplicate_filter_relay_unit_tb;
  import mdfr_pkg::*;

  localparam int unsigned IDLE_LIMIT = 3000;  // cycles with no transfer before giving up
  localparam int unsigned TAIL_WAIT  = 120;   // outlasts the longest walk through the store
  localparam int unsigned RECENT_MAX = 24;    // frames kept for resends, deeper than the store

  localparam logic [MAC_W-1:0] MAC_ONES = {MAC_W{1'b1}};
  localparam logic [ID_W-1:0]  ID_ONES  = {ID_W{1'b1}};

  // one parsed frame header as the bench sees it
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [MAC_W-1:0]  origin;
    logic [MAC_W-1:0]  target;
    logic [ID_W-1:0]   id;
    logic [MAC_W-1:0]  sender;
  } frame_hdr_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [MAC_W-1:0]   cfg_wdata;
  logic               s_tvalid;
  logic               s_tready;
  logic [159:0]       s_tdata;   // origin_mac, target_mac, msg_id, sender_mac
  logic [7:0]         s_tuser;   // msg_kind
  logic               m_tvalid;
  logic               m_tready;
  logic [7:0]         m_tdata;   // occupancy, zero pad
  logic [2:0]         m_tuser;   // action

  // bench copy of the seen-message store, index 0 newest
  logic [MAC_W-1:0]   seen_origin_q [ENTRIES_D];
  logic [MAC_W-1:0]   seen_sender_q [ENTRIES_D];
  logic [ID_W-1:0]    seen_id_q     [ENTRIES_D];
  logic [MAC_W-1:0]   node_addr;

  res_t               pending_verdicts [$];
  frame_hdr_t         recent_frames [$];
  logic [MAC_W-1:0]   origin_pool [6];

  int                 src_idle_pct;
  int                 sink_stall_pct;
  int                 mismatch_count;
  int unsigned        quiet_cycles;

  mesh_duplicate_filter_relay_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // verdict predictor
  // ---------------------------------------------------------------------------

  // length of the leading run of slots holding a nonzero id
  function automatic int unsigned live_run();
    int unsigned n;
    n = 0;
    while (n < ENTRIES_D && seen_id_q[n] != '0) n++;
    return n;
  endfunction

  // decides the verdict for one frame and updates the store copy
  function automatic res_t filter_frame(frame_hdr_t f);
    res_t        r;
    int unsigned n;
    int unsigned i;
    n = live_run();
    r.occupancy = n[OCC_W-1:0];
    // frames that came back to their originator never touch the store
    if (f.origin == node_addr) begin
      r.action = ACT_OWN;
      return r;
    end
    // only the live run is searched; a zero id can never hit
    for (i = 0; i < n; i++) begin
      if (seen_id_q[i] == f.id && seen_origin_q[i] == f.origin) begin
        r.action = ACT_DUP;
        return r;
      end
    end
    // shift the live run back by one, the oldest drops off when full
    if (n >= ENTRIES_D) n = ENTRIES_D - 1;
    for (i = n; i > 0; i--) begin
      seen_origin_q[i] = seen_origin_q[i-1];
      seen_sender_q[i] = seen_sender_q[i-1];
      seen_id_q[i]     = seen_id_q[i-1];
    end
    seen_origin_q[0] = f.origin;
    seen_sender_q[0] = f.sender;
    seen_id_q[0]     = f.id;
    if (f.target == node_addr)
      r.action = ACT_DELIVER;
    else if (f.kind == KIND_BCAST)
      r.action = ACT_BCAST;
    else if (f.kind == KIND_TARGETED)
      r.action = ACT_TARGETED;
    else
      r.action = ACT_PASS;
    n = live_run();
    r.occupancy = n[OCC_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[MAC_W-1:0];
  endfunction

  function automatic frame_hdr_t hdr(logic [KIND_W-1:0] kind, logic [MAC_W-1:0] origin,
                                     logic [MAC_W-1:0] target, logic [ID_W-1:0] id,
                                     logic [MAC_W-1:0] sender);
    frame_hdr_t f;
    f.kind   = kind;
    f.origin = origin;
    f.target = target;
    f.id     = id;
    f.sender = sender;
    return f;
  endfunction

  // mostly plausible mesh traffic: fresh frames, resends, own echoes, a few empty ids
  function automatic frame_hdr_t make_frame();
    frame_hdr_t  f;
    int unsigned pick;
    int unsigned tsel;
    pick = $urandom_range(99);
    if (pick < 35) f.kind = KIND_BCAST;
    else if (pick < 70) f.kind = KIND_TARGETED;
    else f.kind = KIND_W'($urandom_range(255));
    f.sender = rand_mac();
    pick = $urandom_range(99);
    if (pick < 5) begin
      f.origin = node_addr;
      f.id     = ID_W'($urandom_range(65535));
    end else if (pick < 40 && recent_frames.size() > 0) begin
      // resend of a frame heard lately, usually via another neighbor
      f.origin = recent_frames[$urandom_range(recent_frames.size() - 1)].origin;
      f.id     = recent_frames[$urandom_range(recent_frames.size() - 1)].id;
      if ($urandom_range(1) == 1) begin
        f = recent_frames[$urandom_range(recent_frames.size() - 1)];
        f.sender = rand_mac();
      end
    end else begin
      f.origin = ($urandom_range(1) == 1) ? origin_pool[$urandom_range(5)] : rand_mac();
      f.id     = (pick < 43) ? '0 : ID_W'($urandom_range(65535, 1));
    end
    tsel = $urandom_range(99);
    if (tsel < 25) f.target = node_addr;
    else if (tsel < 35) f.target = '0;
    else if (tsel < 40) f.target = MAC_ONES;
    else f.target = rand_mac();
    return f;
  endfunction

  // one frame over the input stream; the verdict is predicted at the transfer
  task automatic send_frame(input frame_hdr_t f);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f.kind;
    s_tdata  <= {f.sender, f.id, f.target, f.origin};
    do @(posedge clk); while (!s_tready);
    pending_verdicts.push_back(filter_frame(f));
    recent_frames.push_back(f);
    if (recent_frames.size() > RECENT_MAX) void'(recent_frames.pop_front());
  endtask

  // holds the input stream off until every verdict is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  // self address written only while the block is idle
  task automatic set_node_addr(input logic [MAC_W-1:0] addr);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    node_addr = addr;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every action, field extremes, duplicates and the empty-id hiding rule
  task automatic test_directed();
    logic [MAC_W-1:0] a, b, c, d, t;
    a = 48'h0200_0000_00A1;
    b = 48'h0200_0000_00B2;
    c = 48'h0200_0000_00C3;
    d = 48'h0200_0000_00D4;
    t = 48'h0200_0000_00E5;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_node_addr(48'h0A1B_2C3D_4E5F);
    send_frame(hdr(KIND_BCAST, node_addr, '0, 16'd9, a));          // own frame, empty store
    send_frame(hdr(KIND_BCAST, a, '0, 16'd1, b));                  // broadcast relay
    send_frame(hdr(KIND_TARGETED, b, t, 16'd1, a));                // targeted relay
    send_frame(hdr(KIND_TARGETED, c, node_addr, 16'd7, a));        // delivery here
    send_frame(hdr(KIND_BCAST, c, node_addr, 16'd8, d));           // delivery wins over kind
    send_frame(hdr(8'd0, d, t, 16'd5, a));                         // unrelayed kinds
    send_frame(hdr(8'd255, d, MAC_ONES, 16'd6, b));
    send_frame(hdr(8'd3, a, t, 16'd2, c));
    send_frame(hdr(KIND_BCAST, a, '0, 16'd1, d));                  // duplicate, other neighbor
    send_frame(hdr(KIND_BCAST, d, '0, 16'd1, a));                  // same id, other origin
    send_frame(hdr(KIND_TARGETED, a, t, 16'd3, b));                // same origin, other id
    send_frame(hdr(8'd255, MAC_ONES, MAC_ONES, ID_ONES, MAC_ONES));
    send_frame(hdr(8'd0, '0, '0, 16'd1, '0));
    send_frame(hdr(KIND_BCAST, MAC_ONES, '0, ID_ONES, c));         // duplicate of extremes
    send_frame(hdr(KIND_BCAST, node_addr, node_addr, 16'd4, a));   // own frame, partly filled store
    send_frame(hdr(KIND_BCAST, a, '0, 16'd0, b));                  // empty id hides the run
    send_frame(hdr(KIND_BCAST, a, '0, 16'd1, b));                  // hidden entry, stored again
    send_frame(hdr(KIND_TARGETED, a, t, 16'd0, c));                // empty id never matches
    send_frame(hdr(KIND_TARGETED, node_addr, t, 16'd0, c));        // own frame, empty run
  endtask

  // more distinct frames than slots, then resends of fallen-off and recent ones
  task automatic test_store_wrap();
    frame_hdr_t burst [20];
    int         k;
    sink_stall_pct = 46;
    for (k = 0; k < 20; k++) begin
      burst[k] = hdr(KIND_BCAST, rand_mac(), rand_mac(), ID_W'(k + 100), rand_mac());
      send_frame(burst[k]);
    end
    for (k = 0; k < 3; k++) send_frame(burst[k]);    // fell off the back, new again
    send_frame(burst[19]);                           // still held, duplicate
    send_frame(burst[3]);                            // fell off the back too, new again
    send_frame(burst[4]);
  endtask

  // random traffic under one idling mix and one self address
  task automatic test_random_traffic(input int unsigned items, input int src_pct,
                                     input int sink_pct, input logic [MAC_W-1:0] addr,
                                     input bit drain_often);
    int unsigned k;
    set_node_addr(addr);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    for (k = 0; k < items; k++) begin
      send_frame(make_frame());
      if (drain_often && k % 60 == 59) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) m_tready <= ($urandom_range(99) >= sink_stall_pct);

  // each output transfer is matched against the oldest predicted verdict
  always @(posedge clk) begin : check_verdicts
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected verdict: expected none, actual action %0d occupancy %0d",
                 $time, m_tuser, m_tdata);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_tuser !== want.action) begin
          mismatch_count++;
          $display("%0t action: expected %0d, actual %0d", $time, want.action, m_tuser);
        end
        if (m_tdata !== {3'b000, want.occupancy}) begin
          mismatch_count++;
          $display("%0t occupancy: expected %0d, actual %0d", $time, want.occupancy,
                   m_tdata);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // run sequence
  // ---------------------------------------------------------------------------

  initial begin
    int k;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    m_tready       = 1'b0;
    node_addr      = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    for (k = 0; k < ENTRIES_D; k++) begin
      seen_origin_q[k] = '0;
      seen_sender_q[k] = '0;
      seen_id_q[k]     = '0;
    end
    for (k = 0; k < 6; k++) origin_pool[k] = rand_mac();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_store_wrap();
    test_random_traffic(315, 0, 0, MAC_ONES, 1'b0);    // back to back
    test_random_traffic(315, 46, 0, '0, 1'b0);         // sender gaps, all-zero self
    test_random_traffic(315, 0, 46, rand_mac(), 1'b0); // receiver stalls
    test_random_traffic(315, 17, 17, rand_mac(), 1'b1); // both, drained now and then

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
